[sv/clsq_pkg.sv]
// Shared types and constants of the character LCD write sequencer.
// Holds the request and pulse word structs, function codes and LCD command bytes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package clsq_pkg;

  localparam logic [2:0] FUNC_CMD   = 3'd0;
  localparam logic [2:0] FUNC_CHAR  = 3'd1;
  localparam logic [2:0] FUNC_POS   = 3'd2;
  localparam logic [2:0] FUNC_CLEAR = 3'd3;
  localparam logic [2:0] FUNC_INIT  = 3'd4;

  localparam logic REG_FOUR_BIT_MODE   = 1'b0;
  localparam logic REG_ENABLE_WIDTH_MS = 1'b1;

  localparam logic [7:0] LCD_RESET        = 8'h30;
  localparam logic [7:0] LCD_FUNC_8BIT    = 8'h38;
  localparam logic [7:0] LCD_FUNC_4BIT    = 8'h28;
  localparam logic [7:0] LCD_DISPLAY_ON   = 8'h0C;
  localparam logic [7:0] LCD_CLEAR        = 8'h01;
  localparam logic [7:0] LCD_ENTRY_MODE   = 8'h06;
  localparam logic [7:0] LCD_HOME         = 8'h02;
  localparam logic [7:0] LCD_SET_DDRAM    = 8'h80;
  localparam logic [7:0] LCD_ROW1_OFFSET  = 8'h40;

  localparam logic [5:0] POWER_UP_WAIT_MS = 6'd40;
  localparam logic [3:0] INIT_RESET_COUNT = 4'd3;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] value;
    logic       row;
  } req_t;

  typedef struct packed {
    logic       reg_select;
    logic [7:0] bus_value;
    logic [5:0] wait_before_ms;
    logic [2:0] wait_after_ms;
    logic       last_pulse;
  } pulse_t;

endpackage

`default_nettype wire

[sv/clsq_pulse_gen.sv]
// Pulse generator: maps a held request and a pulse index to one enable pulse word.
// Depends on clsq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module clsq_pulse_gen
  import clsq_pkg::*;
(
  input  var req_t       req,
  input  var logic       four_bit_mode,
  input  var logic [3:0] idx,
  output var pulse_t     pulse
);

  logic [7:0] byte_val;
  logic [2:0] byte_after;
  logic       rs;
  logic       half;
  logic       is_last_byte;
  logic [3:0] init_pos;
  logic [2:0] init_byte;

  assign init_pos  = idx - INIT_RESET_COUNT;
  assign init_byte = four_bit_mode ? init_pos[3:1] : init_pos[2:0];

  always_comb begin
    byte_val     = LCD_CLEAR;
    byte_after   = 3'd0;
    rs           = 1'b0;
    half         = idx[0];
    is_last_byte = 1'b1;
    case (req.func)
      FUNC_CMD: begin
        byte_val = req.value;
      end
      FUNC_CHAR: begin
        byte_val   = req.value;
        rs         = 1'b1;
        byte_after = 3'd1;
      end
      FUNC_POS: begin
        byte_val   = req.row ? ((LCD_ROW1_OFFSET + req.value) | LCD_SET_DDRAM)
                             : (req.value | LCD_SET_DDRAM);
        byte_after = 3'd1;
      end
      FUNC_CLEAR: begin
        byte_val   = LCD_CLEAR;
        byte_after = 3'd2;
      end
      FUNC_INIT: begin
        half         = init_pos[0];
        is_last_byte = (init_byte == 3'd5);
        case (init_byte)
          3'd0: begin
            byte_val   = four_bit_mode ? LCD_FUNC_4BIT : LCD_FUNC_8BIT;
            byte_after = 3'd1;
          end
          3'd1: begin
            byte_val   = four_bit_mode ? LCD_FUNC_4BIT : LCD_FUNC_8BIT;
            byte_after = four_bit_mode ? 3'd1 : 3'd0;
          end
          3'd2: begin
            byte_val   = LCD_DISPLAY_ON;
            byte_after = 3'd1;
          end
          3'd3: begin
            byte_val   = LCD_CLEAR;
            byte_after = 3'd2;
          end
          3'd4: begin
            byte_val   = LCD_ENTRY_MODE;
            byte_after = 3'd1;
          end
          default: begin
            byte_val   = LCD_HOME;
            byte_after = 3'd2;
          end
        endcase
      end
      default: begin
        byte_val = LCD_CLEAR;
      end
    endcase
  end

  always_comb begin
    pulse.reg_select     = rs;
    pulse.wait_before_ms = 6'd0;
    if (four_bit_mode) begin
      pulse.bus_value     = half ? {byte_val[3:0], 4'h0} : {byte_val[7:4], 4'h0};
      pulse.wait_after_ms = half ? byte_after : 3'd0;
      pulse.last_pulse    = half && is_last_byte;
    end else begin
      pulse.bus_value     = byte_val;
      pulse.wait_after_ms = byte_after;
      pulse.last_pulse    = is_last_byte;
    end
    // reset sequence ahead of the init bytes
    if (req.func == FUNC_INIT && idx < INIT_RESET_COUNT) begin
      pulse.bus_value      = LCD_RESET;
      pulse.wait_before_ms = (idx == 4'd0) ? POWER_UP_WAIT_MS : 6'd0;
      pulse.last_pulse     = 1'b0;
      if (four_bit_mode) begin
        pulse.wait_after_ms = 3'd2;
      end else begin
        pulse.wait_after_ms = (idx == 4'd0) ? 3'd5 : 3'd1;
      end
    end
  end

endmodule

`default_nettype wire

[sv/char_lcd_write_sequencer_core.sv]
// Character LCD write sequencer: turns each request word into its run of enable pulse words
// (8-bit or 4-bit bus). Top level; depends on clsq_pkg and clsq_pulse_gen.
//
// One pulse word leaves per cycle while pulse_ready is high. A request occupies the
// request register until its last pulse is loaded: one pulse (8-bit) or two (4-bit) for
// command, character, position and clear; nine (8-bit) or fifteen (4-bit) for init. The
// next request is taken in the cycle that loads the previous request's last pulse into
// the output register, so requests follow back to back; a request with an unknown
// function is accepted and yields no pulse. The output register stalls the whole chain
// while it holds a word and pulse_ready is low. Write the configuration registers only
// while idle; enable_width_ms belongs to the external pulse timer and is not held here.
`timescale 1ns / 1ps
`default_nettype none

module char_lcd_write_sequencer_core
  import clsq_pkg::*;
(
  input  var logic       clk,
  input  var logic       rst,
  input  var logic       wr_en,
  input  var logic       wr_index,
  input  var logic [3:0] wr_data,
  input  var logic       cmd_valid,
  output var logic       cmd_ready,
  input  var req_t       cmd,
  output var logic       pulse_valid,
  input  var logic       pulse_ready,
  output var pulse_t     pulse
);

  logic       four_bit_mode;
  logic       cur_valid;
  req_t       cur;
  logic [3:0] idx;
  pulse_t     gen_pulse;
  logic       load;
  logic       cmd_take;
  logic       func_ok;

  clsq_pulse_gen u_gen (
    .req           (cur),
    .four_bit_mode (four_bit_mode),
    .idx           (idx),
    .pulse         (gen_pulse)
  );

  assign load      = !pulse_valid || pulse_ready;
  assign cmd_ready = !cur_valid || (load && gen_pulse.last_pulse);
  assign cmd_take  = cmd_valid && cmd_ready;
  assign func_ok   = (cmd.func <= FUNC_INIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      four_bit_mode <= 1'b0;
    end else if (wr_en && wr_index == REG_FOUR_BIT_MODE) begin
      four_bit_mode <= wr_data[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 4'd0;
    end else if (cmd_take) begin
      cur_valid <= func_ok;
      idx       <= 4'd0;
    end else if (cur_valid && load) begin
      cur_valid <= !gen_pulse.last_pulse;
      idx       <= idx + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      cur <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_valid <= 1'b0;
    end else if (load) begin
      pulse_valid <= cur_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cur_valid && load) begin
      pulse <= gen_pulse;
    end
  end

  a_unknown_dropped: assert property (@(posedge clk) disable iff (rst)
    cmd_take && !func_ok |=> !cur_valid)
    else $error("unknown function request was held");

  a_start_index: assert property (@(posedge clk) disable iff (rst)
    cmd_take && func_ok |=> cur_valid && idx == 4'd0)
    else $error("request did not start at pulse zero");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    cur_valid && load && !gen_pulse.last_pulse |=> cur_valid && idx == $past(idx) + 4'd1)
    else $error("pulse index did not advance");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> idx <= 4'd14)
    else $error("pulse index beyond longest sequence");

  a_load_moves_out: assert property (@(posedge clk) disable iff (rst)
    cur_valid && load |=> pulse_valid)
    else $error("generated pulse not presented");

endmodule

`default_nettype wire

[tb/sv/char_lcd_write_sequencer_core_tb.sv]
// Self-checking testbench of the character LCD write sequencer, 8-bit and 4-bit bus modes.
// Directed and random requests are checked word by word against typed or predicted words.
// Depends on clsq_pkg and char_lcd_write_sequencer_core.
`timescale 1ns / 1ps

module char_lcd_write_sequencer_core_tb;
  import clsq_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RAND_PHASES  = 4;
  localparam int PHASE_ITEMS  = 36;
  localparam int DIR_ROWS     = 12;

  localparam logic RS_INSTR = 1'b0;
  localparam logic RS_DATA  = 1'b1;

  typedef enum logic [1:0] {ROW_PREDICT, ROW_ONE, ROW_NONE} row_kind_e;

  typedef struct packed {
    req_t      req;
    row_kind_e kind;
    pulse_t    typed;
  } dir_row_t;

  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{'{FUNC_CMD,   8'h00, 1'b0}, ROW_ONE,  '{RS_INSTR, 8'h00, 6'd0, 3'd0, 1'b1}},
    '{'{FUNC_CMD,   8'hFF, 1'b1}, ROW_ONE,  '{RS_INSTR, 8'hFF, 6'd0, 3'd0, 1'b1}},
    '{'{FUNC_CHAR,  8'h00, 1'b0}, ROW_ONE,  '{RS_DATA,  8'h00, 6'd0, 3'd1, 1'b1}},
    '{'{FUNC_CHAR,  8'hFF, 1'b1}, ROW_ONE,  '{RS_DATA,  8'hFF, 6'd0, 3'd1, 1'b1}},
    '{'{FUNC_POS,   8'h00, 1'b0}, ROW_ONE,  '{RS_INSTR, 8'h80, 6'd0, 3'd1, 1'b1}},
    '{'{FUNC_POS,   8'h7F, 1'b0}, ROW_ONE,  '{RS_INSTR, 8'hFF, 6'd0, 3'd1, 1'b1}},
    '{'{FUNC_POS,   8'h00, 1'b1}, ROW_ONE,  '{RS_INSTR, 8'hC0, 6'd0, 3'd1, 1'b1}},
    '{'{FUNC_POS,   8'hFF, 1'b1}, ROW_ONE,  '{RS_INSTR, 8'hBF, 6'd0, 3'd1, 1'b1}},
    '{'{FUNC_CLEAR, 8'h5A, 1'b1}, ROW_ONE,  '{RS_INSTR, LCD_CLEAR, 6'd0, 3'd2, 1'b1}},
    '{'{FUNC_INIT,  8'hA5, 1'b0}, ROW_PREDICT, '0},
    '{'{3'd5,       8'hAA, 1'b1}, ROW_NONE, '0},
    '{'{3'd7,       8'h55, 1'b0}, ROW_NONE, '0}
  };

  logic   clk;
  logic   rst;
  logic   wr_en;
  logic   wr_index;
  logic   [3:0] wr_data;
  logic   cmd_valid;
  logic   cmd_ready;
  req_t   cmd;
  logic   pulse_valid;
  logic   pulse_ready;
  pulse_t pulse;

  logic       mode_4bit;
  logic       no_idle;
  row_kind_e  row_kind;
  pulse_t     row_pulse;

  pulse_t lcd_pulse_q [$];
  pulse_t pulse_batch [$];
  pulse_t want;

  int err_count;
  int cycle_count;
  int req_count;
  int init_count;
  int unknown_count;
  int pulse_count;

  char_lcd_write_sequencer_core u_dut (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (wr_en),
    .wr_index    (wr_index),
    .wr_data     (wr_data),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .cmd         (cmd),
    .pulse_valid (pulse_valid),
    .pulse_ready (pulse_ready),
    .pulse       (pulse)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void add_pulse(logic rs, logic [7:0] bus, logic [5:0] pre_ms,
                                    logic [2:0] after);
    pulse_t p;
    p = '{rs, bus, pre_ms, after, 1'b0};
    pulse_batch.push_back(p);
  endfunction

  function automatic void add_byte(logic rs, logic [7:0] b, logic [2:0] after);
    if (mode_4bit) begin
      add_pulse(rs, {b[7:4], 4'h0}, 6'd0, 3'd0);
      add_pulse(rs, {b[3:0], 4'h0}, 6'd0, after);
    end else begin
      add_pulse(rs, b, 6'd0, after);
    end
  endfunction

  function automatic void predict_pulses(req_t r);
    pulse_batch.delete();
    case (r.func)
      FUNC_CMD: add_byte(RS_INSTR, r.value, 3'd0);
      FUNC_CHAR: add_byte(RS_DATA, r.value, 3'd1);
      FUNC_POS: begin
        if (r.row)
          add_byte(RS_INSTR, 8'(LCD_ROW1_OFFSET + r.value) | LCD_SET_DDRAM, 3'd1);
        else
          add_byte(RS_INSTR, r.value | LCD_SET_DDRAM, 3'd1);
      end
      FUNC_CLEAR: add_byte(RS_INSTR, LCD_CLEAR, 3'd2);
      FUNC_INIT: begin
        if (mode_4bit) begin
          add_pulse(RS_INSTR, LCD_RESET, POWER_UP_WAIT_MS, 3'd2);
          add_pulse(RS_INSTR, LCD_RESET, 6'd0, 3'd2);
          add_pulse(RS_INSTR, LCD_RESET, 6'd0, 3'd2);
          add_byte(RS_INSTR, LCD_FUNC_4BIT, 3'd1);
          add_byte(RS_INSTR, LCD_FUNC_4BIT, 3'd1);
        end else begin
          add_pulse(RS_INSTR, LCD_RESET, POWER_UP_WAIT_MS, 3'd5);
          add_pulse(RS_INSTR, LCD_RESET, 6'd0, 3'd1);
          add_pulse(RS_INSTR, LCD_RESET, 6'd0, 3'd1);
          add_byte(RS_INSTR, LCD_FUNC_8BIT, 3'd1);
          add_byte(RS_INSTR, LCD_FUNC_8BIT, 3'd0);
        end
        add_byte(RS_INSTR, LCD_DISPLAY_ON, 3'd1);
        add_byte(RS_INSTR, LCD_CLEAR, 3'd2);
        add_byte(RS_INSTR, LCD_ENTRY_MODE, 3'd1);
        add_byte(RS_INSTR, LCD_HOME, 3'd2);
      end
      default: ;
    endcase
    if (pulse_batch.size() > 0)
      pulse_batch[pulse_batch.size() - 1].last_pulse = 1'b1;
    foreach (pulse_batch[i])
      lcd_pulse_q.push_back(pulse_batch[i]);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
    err_count++;
    $display("mismatch: %s got 0x%0h want 0x%0h at pulse word %0d", what, got, exp_val,
             pulse_count);
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(posedge clk) begin
    pulse_ready <= no_idle || ($urandom_range(0, 99) >= 26);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cmd_valid && cmd_ready) begin
        req_count++;
        if (cmd.func == FUNC_INIT)
          init_count++;
        if (cmd.func > FUNC_INIT)
          unknown_count++;
        case (row_kind)
          ROW_ONE: lcd_pulse_q.push_back(row_pulse);
          ROW_NONE: ;
          default: predict_pulses(cmd);
        endcase
      end
      if (pulse_valid && pulse_ready) begin
        pulse_count++;
        if (lcd_pulse_q.size() == 0) begin
          report_mismatch("unexpected pulse word", 32'(pulse), 0);
        end else begin
          want = lcd_pulse_q.pop_front();
          if (pulse.reg_select !== want.reg_select)
            report_mismatch("reg_select", 32'(pulse.reg_select), 32'(want.reg_select));
          if (pulse.bus_value !== want.bus_value)
            report_mismatch("bus_value", 32'(pulse.bus_value), 32'(want.bus_value));
          if (pulse.wait_before_ms !== want.wait_before_ms)
            report_mismatch("wait_before_ms", 32'(pulse.wait_before_ms),
                            32'(want.wait_before_ms));
          if (pulse.wait_after_ms !== want.wait_after_ms)
            report_mismatch("wait_after_ms", 32'(pulse.wait_after_ms),
                            32'(want.wait_after_ms));
          if (pulse.last_pulse !== want.last_pulse)
            report_mismatch("last_pulse", 32'(pulse.last_pulse), 32'(want.last_pulse));
        end
      end
    end
  end

  task automatic set_config(logic mode, logic [3:0] width);
    wr_en    <= 1'b1;
    wr_index <= REG_FOUR_BIT_MODE;
    wr_data  <= {3'b000, mode};
    @(posedge clk);
    wr_index <= REG_ENABLE_WIDTH_MS;
    wr_data  <= width;
    @(posedge clk);
    wr_en <= 1'b0;
    mode_4bit = mode;
    @(posedge clk);
  endtask

  task automatic sender_gap();
    int n;
    n = 0;
    if (!no_idle)
      while ($urandom_range(0, 99) < 26)
        n++;
    if (n > 0) begin
      cmd_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_req(req_t r, row_kind_e k, pulse_t p);
    sender_gap();
    cmd       <= r;
    cmd_valid <= 1'b1;
    row_kind  <= k;
    row_pulse <= p;
    do @(posedge clk); while (!cmd_ready);
  endtask

  // hold off until every expected word is out, then let the block settle
  task automatic drain();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (lcd_pulse_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic req_t rand_req();
    req_t r;
    int pick;
    pick    = $urandom_range(0, 99);
    r.value = 8'($urandom_range(0, 255));
    r.row   = 1'($urandom_range(0, 1));
    if (pick < 24)
      r.func = FUNC_CMD;
    else if (pick < 48)
      r.func = FUNC_CHAR;
    else if (pick < 74)
      r.func = FUNC_POS;
    else if (pick < 84)
      r.func = FUNC_CLEAR;
    else if (pick < 96)
      r.func = FUNC_INIT;
    else
      r.func = 3'($urandom_range(FUNC_INIT + 1, 7));
    return r;
  endfunction

  initial begin
    rst            = 1'b1;
    wr_en          = 1'b0;
    wr_index       = REG_FOUR_BIT_MODE;
    wr_data        = 4'd0;
    cmd_valid      = 1'b0;
    cmd            = '0;
    pulse_ready    = 1'b0;
    mode_4bit      = 1'b0;
    no_idle        = 1'b0;
    row_kind       = ROW_PREDICT;
    row_pulse      = '0;
    err_count      = 0;
    cycle_count    = 0;
    req_count      = 0;
    init_count     = 0;
    unknown_count  = 0;
    pulse_count    = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_config(1'b0, 4'd1);
    for (int i = 0; i < DIR_ROWS; i++)
      send_req(DIR_TAB[i].req, DIR_TAB[i].kind, DIR_TAB[i].typed);
    drain();

    set_config(1'b1, 4'd15);
    for (int i = 0; i < DIR_ROWS; i++)
      send_req(DIR_TAB[i].req, ROW_PREDICT, '0);
    drain();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: set_config(1'b1, 4'd15);
        1: set_config(1'b0, 4'd15);
        2: set_config(1'b1, 4'd1);
        default: set_config(1'($urandom_range(0, 1)), 4'($urandom_range(1, 15)));
      endcase
      if (ph == 2)
        no_idle <= 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k == PHASE_ITEMS / 2 && ph != 2)
          drain();
        send_req(rand_req(), ROW_PREDICT, '0);
        if (ph == 2 && k == 30)
          no_idle <= 1'b0;
      end
      drain();
    end

    if (lcd_pulse_q.size() != 0)
      report_mismatch("pulse words never sent", 32'(lcd_pulse_q.size()), 0);
    $display("Covered %0d requests (%0d init, %0d unknown function) over 8-bit and 4-bit modes;",
             req_count, init_count, unknown_count);
    $display("checked %0d pulse words, %0d mismatches.", pulse_count, err_count);
    if (err_count == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

[sim.f]
sv/clsq_pkg.sv
sv/clsq_pulse_gen.sv
sv/char_lcd_write_sequencer_core.sv
tb/sv/char_lcd_write_sequencer_core_tb.sv
